@@ hw/rtl/icqs_pkg.sv @@
// Package for the image capture query sequencer: item and state types,
// phase, operation, query and status codes, register indexes and reset values.
// No dependencies.
package icqs_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;

    // Query kinds
    localparam logic [2:0] QK_NONE      = 3'd0;
    localparam logic [2:0] QK_HANDSHAKE = 3'd1;
    localparam logic [2:0] QK_HEALTH    = 3'd2;
    localparam logic [2:0] QK_PARAMS    = 3'd3;
    localparam logic [2:0] QK_SIZE      = 3'd4;
    localparam logic [2:0] QK_PACKET    = 3'd5;
    localparam logic [2:0] QK_SHUTDOWN  = 3'd6;

    // Run status
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TIMEOUT_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL_MS = 2'd2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [15:0] RST_BUFFER_CAPACITY   = 16'd65535;
    localparam logic [31:0] RST_PHASE_TIMEOUT_MS  = 32'd30000;
    localparam logic [31:0] RST_RETRY_INTERVAL_MS = 32'd100;

    typedef enum logic [7:0] {
        PH_HANDSHAKE = 8'b0000_0001,
        PH_HEALTH    = 8'b0000_0010,
        PH_PARAMS    = 8'b0000_0100,
        PH_SIZE      = 8'b0000_1000,
        PH_PACKET    = 8'b0001_0000,
        PH_SHUTDOWN  = 8'b0010_0000,
        PH_DONE      = 8'b0100_0000,
        PH_ERROR     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic        resp_ok;
        logic [7:0]  health_status;
        logic [15:0] reported_size;
        logic [15:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  query_kind;
        logic        resend_request;
        logic [15:0] write_offset;
        logic        write_enable;
        logic [1:0]  run_status;
        logic [15:0] bytes_total;
    } t_out_item;

    typedef struct packed {
        logic [15:0] buffer_capacity;
        logic [31:0] phase_timeout_ms;
        logic [31:0] retry_interval_ms;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] phase_start;
        logic [31:0] last_attempt;
        logic [15:0] expected_size;
        logic [15:0] received_count;
        logic        resend_flag;
        logic        query_outstanding;
    } t_state;

endpackage

@@ hw/rtl/icqs_if.sv @@
// Valid/ready channel interfaces for sequencer items and results.
// Depends on icqs_pkg.
interface icqs_in_if import icqs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface icqs_out_if import icqs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/image_capture_query_sequencer.sv @@
// Top level of the image capture query sequencer: state and config registers,
// output register. Depends on icqs_pkg, icqs_if.sv and icqs_step.
//
//  channel | dir | payload     | transfer when
//  --------+-----+-------------+------------------------------------
//  i_in    | in  | t_in_item   | i_in.valid && i_in.ready
//  o_out   | out | t_out_item  | o_out.valid && o_out.ready
//  cfg     | in  | idx, data   | i_cfg_we high (no handshake)
//
// One item per cycle while the output drains: the step logic runs straight
// off the input payload and its result lands in the output register at the
// same edge as the state; o_out.valid rises in the cycle after the transfer.
// i_in.ready drops only while a result sits in the output register and the
// sink holds o_out.ready low; the next item is taken in the cycle it is freed.
// Synchronous active-low reset: phase goes to done (idle), counters and
// timestamps to zero, config registers to their defaults, output empty.
module image_capture_query_sequencer import icqs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    icqs_in_if.sink              i_in,
    icqs_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state    r_state;
    t_state    n_state;
    t_cfg      r_cfg;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_xfer;

    // output register drains or is empty: room for a new result
    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign in_xfer       = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    icqs_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in.payload),
        .o_next   (n_state),
        .o_result (n_out)
    );

    // sequencer state advances only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase             <= PH_DONE;
            r_state.phase_start       <= '0;
            r_state.last_attempt      <= '0;
            r_state.expected_size     <= '0;
            r_state.received_count    <= '0;
            r_state.resend_flag       <= 1'b0;
            r_state.query_outstanding <= 1'b0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // config writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_capacity   <= RST_BUFFER_CAPACITY;
            r_cfg.phase_timeout_ms  <= RST_PHASE_TIMEOUT_MS;
            r_cfg.retry_interval_ms <= RST_RETRY_INTERVAL_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUFFER_CAPACITY:   r_cfg.buffer_capacity   <= i_cfg_data[15:0];
                CFG_PHASE_TIMEOUT_MS:  r_cfg.phase_timeout_ms  <= i_cfg_data[31:0];
                CFG_RETRY_INTERVAL_MS: r_cfg.retry_interval_ms <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // output register: valid is control, payload loads on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

endmodule

@@ hw/rtl/icqs_step.sv @@
// Next-state and result logic for one sequencer item.
// Depends on icqs_pkg.
module icqs_step import icqs_pkg::*; (
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_state    o_next,
    output t_out_item o_result
);

    logic [31:0] since_start;
    logic [31:0] since_attempt;
    logic [16:0] fill_sum;
    logic        pkt_fits;
    logic        size_ok;

    assign since_start   = i_item.now_ms - i_state.phase_start;
    assign since_attempt = i_item.now_ms - i_state.last_attempt;
    assign fill_sum      = {1'b0, i_state.received_count} + {1'b0, i_item.packet_length};
    assign pkt_fits      = (i_item.packet_length != 16'd0)
                         && (fill_sum <= {1'b0, i_cfg.buffer_capacity});
    assign size_ok       = (i_item.reported_size != 16'd0)
                         && (i_item.reported_size <= i_cfg.buffer_capacity);

    always_comb begin
        o_next   = i_state;
        o_result = '0;

        unique case (i_item.operation)
            OP_START: begin
                o_next.expected_size     = '0;
                o_next.received_count    = '0;
                o_next.resend_flag       = 1'b0;
                o_next.query_outstanding = 1'b0;
                o_next.phase             = PH_HANDSHAKE;
                o_next.phase_start       = i_item.now_ms;
                o_next.last_attempt      = '0;
            end
            OP_TICK: begin
                if (i_state.phase != PH_DONE && i_state.phase != PH_ERROR) begin
                    if (since_start > i_cfg.phase_timeout_ms) begin
                        o_next.phase             = PH_ERROR;
                        o_next.query_outstanding = 1'b0;
                    end else if (since_attempt >= i_cfg.retry_interval_ms) begin
                        o_next.last_attempt      = i_item.now_ms;
                        o_next.query_outstanding = 1'b1;
                        unique case (i_state.phase)
                            PH_HANDSHAKE: o_result.query_kind = QK_HANDSHAKE;
                            PH_HEALTH:    o_result.query_kind = QK_HEALTH;
                            PH_PARAMS:    o_result.query_kind = QK_PARAMS;
                            PH_SIZE:      o_result.query_kind = QK_SIZE;
                            PH_PACKET:    o_result.query_kind = QK_PACKET;
                            default:      o_result.query_kind = QK_SHUTDOWN;
                        endcase
                        o_result.resend_request = (i_state.phase == PH_PACKET)
                                                && i_state.resend_flag;
                    end
                end
            end
            OP_RESP: begin
                if (i_state.query_outstanding
                        && i_state.phase != PH_DONE && i_state.phase != PH_ERROR) begin
                    o_next.query_outstanding = 1'b0;
                    unique case (i_state.phase)
                        PH_HANDSHAKE: begin
                            if (i_item.resp_ok) begin
                                o_next.phase        = PH_HEALTH;
                                o_next.phase_start  = i_item.now_ms;
                                o_next.last_attempt = '0;
                            end
                        end
                        PH_HEALTH: begin
                            if (i_item.resp_ok && i_item.health_status == 8'd0) begin
                                o_next.phase        = PH_PARAMS;
                                o_next.phase_start  = i_item.now_ms;
                                o_next.last_attempt = '0;
                            end
                        end
                        PH_PARAMS: begin
                            if (i_item.resp_ok) begin
                                o_next.phase        = PH_SIZE;
                                o_next.phase_start  = i_item.now_ms;
                                o_next.last_attempt = '0;
                            end
                        end
                        PH_SIZE: begin
                            if (i_item.resp_ok && size_ok) begin
                                o_next.expected_size  = i_item.reported_size;
                                o_next.received_count = '0;
                                o_next.resend_flag    = 1'b0;
                                o_next.phase          = PH_PACKET;
                                o_next.phase_start    = i_item.now_ms;
                                o_next.last_attempt   = '0;
                            end
                        end
                        PH_PACKET: begin
                            if (i_item.resp_ok && pkt_fits) begin
                                o_result.write_enable = 1'b1;
                                o_result.write_offset = i_state.received_count;
                                o_next.received_count = fill_sum[15:0];
                                o_next.resend_flag    = 1'b0;
                                if (fill_sum[15:0] >= i_state.expected_size) begin
                                    o_next.phase        = PH_SHUTDOWN;
                                    o_next.phase_start  = i_item.now_ms;
                                    o_next.last_attempt = '0;
                                end else begin
                                    o_next.last_attempt = i_item.now_ms;
                                end
                            end else begin
                                o_next.resend_flag = 1'b1;
                            end
                        end
                        default: begin
                            if (i_item.resp_ok) begin
                                o_next.phase        = PH_DONE;
                                o_next.phase_start  = i_item.now_ms;
                                o_next.last_attempt = '0;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase

        // status reflects the state after this item
        if (o_next.phase == PH_DONE) begin
            o_result.run_status = ST_DONE;
        end else if (o_next.phase == PH_ERROR) begin
            o_result.run_status = ST_ERROR;
        end else begin
            o_result.run_status = ST_BUSY;
        end
        o_result.bytes_total = (o_next.phase == PH_ERROR) ? 16'd0 : o_next.received_count;
    end

endmodule

@@ test/tb.sv @@
// Self-checking bench for image_capture_query_sequencer: directed capture runs, then random
// sessions under several register settings, checked against an in-bench sequencer model.
// Depends on icqs_pkg, the icqs channel interfaces and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icqs_pkg::*;

    // Operation code with no meaning to the block, and a register index past the list
    localparam logic [1:0]           OP_IGNORED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int                   WATCHDOG_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Channel drive lives in local regs so every input is known from time zero
    logic     in_valid = 1'b0;
    t_in_item in_payload = '0;
    logic     out_ready = 1'b0;
    logic     in_fire = 1'b0;

    icqs_in_if  dut_in ();
    icqs_out_if dut_out ();

    assign dut_in.valid   = in_valid;
    assign dut_in.payload = in_payload;
    assign dut_out.ready  = out_ready;

    image_capture_query_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (dut_in),
        .o_out      (dut_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Sequencer model: register copies and sequence state
    // ------------------------------------------------------------------
    logic [15:0] cfg_capacity = RST_BUFFER_CAPACITY;
    logic [31:0] cfg_timeout  = RST_PHASE_TIMEOUT_MS;
    logic [31:0] cfg_retry    = RST_RETRY_INTERVAL_MS;

    t_phase      sq_phase       = PH_DONE;
    logic [31:0] sq_phase_start = '0;
    logic [31:0] sq_last_try    = '0;
    logic [15:0] sq_expected    = '0;
    logic [15:0] sq_received    = '0;
    logic        sq_resend      = 1'b0;
    logic        sq_waiting     = 1'b0;

    t_in_item  capture_items[$];    // items waiting for the driver
    t_out_item awaited_outputs[$];  // predicted results, oldest first

    int          mismatches = 0;
    int          phase_items = 0;
    logic [31:0] gen_ms = '0;       // running millisecond clock of the generator

    int burst_left = 0;
    int gap_left   = 0;
    int rx_cycle   = 0;
    int rx_mode    = 0;
    int quiet_cycles;

    // New phase: timestamp it and clear the attempt time, so the first
    // query of a phase waits until now_ms itself reaches the retry spacing.
    function automatic void enter_phase(t_phase nxt, logic [31:0] now);
        sq_phase       = nxt;
        sq_phase_start = now;
        sq_last_try    = '0;
    endfunction

    function automatic t_out_item sequence_item(t_in_item it);
        t_out_item   res;
        logic [31:0] since_start;
        logic [31:0] since_try;
        logic [16:0] fill;
        res         = '0;
        since_start = it.now_ms - sq_phase_start;
        since_try   = it.now_ms - sq_last_try;
        fill        = {1'b0, sq_received} + {1'b0, it.packet_length};
        case (it.operation)
            OP_START: begin
                // start aborts whatever runs and goes back to the handshake
                sq_expected = '0;
                sq_received = '0;
                sq_resend   = 1'b0;
                sq_waiting  = 1'b0;
                enter_phase(PH_HANDSHAKE, it.now_ms);
            end
            OP_TICK: begin
                if (sq_phase != PH_DONE && sq_phase != PH_ERROR) begin
                    if (since_start > cfg_timeout) begin
                        sq_phase   = PH_ERROR;
                        sq_waiting = 1'b0;
                    end else if (since_try >= cfg_retry) begin
                        // (re)issue; an outstanding query is simply replaced
                        sq_last_try = it.now_ms;
                        sq_waiting  = 1'b1;
                        case (sq_phase)
                            PH_HANDSHAKE: res.query_kind = QK_HANDSHAKE;
                            PH_HEALTH:    res.query_kind = QK_HEALTH;
                            PH_PARAMS:    res.query_kind = QK_PARAMS;
                            PH_SIZE:      res.query_kind = QK_SIZE;
                            PH_PACKET:    res.query_kind = QK_PACKET;
                            default:      res.query_kind = QK_SHUTDOWN;
                        endcase
                        res.resend_request = (sq_phase == PH_PACKET) && sq_resend;
                    end
                end
            end
            OP_RESP: begin
                // stray answers and answers in done/error are dropped
                if (sq_waiting && sq_phase != PH_DONE && sq_phase != PH_ERROR) begin
                    sq_waiting = 1'b0;
                    case (sq_phase)
                        PH_HANDSHAKE: if (it.resp_ok) enter_phase(PH_HEALTH, it.now_ms);
                        PH_HEALTH: begin
                            if (it.resp_ok && it.health_status == 8'd0)
                                enter_phase(PH_PARAMS, it.now_ms);
                        end
                        PH_PARAMS: if (it.resp_ok) enter_phase(PH_SIZE, it.now_ms);
                        PH_SIZE: begin
                            // zero or oversize image counts as a failed query
                            if (it.resp_ok && it.reported_size != 16'd0 &&
                                it.reported_size <= cfg_capacity) begin
                                sq_expected = it.reported_size;
                                sq_received = '0;
                                sq_resend   = 1'b0;
                                enter_phase(PH_PACKET, it.now_ms);
                            end
                        end
                        PH_PACKET: begin
                            if (it.resp_ok && it.packet_length != 16'd0 &&
                                fill <= {1'b0, cfg_capacity}) begin
                                res.write_enable = 1'b1;
                                res.write_offset = sq_received;
                                sq_received      = fill[15:0];
                                sq_resend        = 1'b0;
                                if (sq_received >= sq_expected)
                                    enter_phase(PH_SHUTDOWN, it.now_ms);
                                else
                                    sq_last_try = it.now_ms;
                            end else begin
                                // empty or overflowing packet: ask again
                                sq_resend = 1'b1;
                            end
                        end
                        PH_SHUTDOWN: if (it.resp_ok) enter_phase(PH_DONE, it.now_ms);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (sq_phase == PH_DONE)       res.run_status = ST_DONE;
        else if (sq_phase == PH_ERROR) res.run_status = ST_ERROR;
        else                           res.run_status = ST_BUSY;
        res.bytes_total = (sq_phase == PH_ERROR) ? 16'd0 : sq_received;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report(string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic put_item(logic [1:0] op, logic [31:0] now, logic ok, logic [7:0] health,
                            logic [15:0] size, logic [15:0] len);
        t_in_item it;
        it.operation     = op;
        it.now_ms        = now;
        it.resp_ok       = ok;
        it.health_status = health;
        it.reported_size = size;
        it.packet_length = len;
        capture_items.push_back(it);
        phase_items++;
    endtask

    // Spacing before a tick: mostly just past the retry spacing, sometimes too
    // early, now and then beyond the phase timeout. Tight timeouts get 0/1 ms steps.
    function automatic logic [31:0] tick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cfg_timeout < 64)
            return (r < 75) ? 32'd0 : 32'd1;
        if (r < 4)
            return cfg_timeout + 32'd1 + 32'($urandom_range(0, 50));
        if (r < 14)
            return 32'($urandom_range(0, cfg_retry));
        return cfg_retry + 32'($urandom_range(0, 15));
    endfunction

    // Occasional junk: undefined op, stray answer, extra tick or a restart
    task automatic maybe_noise();
        logic [1:0] op;
        if ($urandom_range(0, 99) >= 8)
            return;
        case ($urandom_range(0, 7))
            0:       op = OP_START;
            1, 2:    op = OP_TICK;
            3, 4:    op = OP_RESP;
            default: op = OP_IGNORED;
        endcase
        put_item(op, (op == OP_IGNORED) ? $urandom : gen_ms, 1'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom));
    endtask

    task automatic issue_tick();
        gen_ms += tick_gap();
        put_item(OP_TICK, gen_ms, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        maybe_noise();
        gen_ms += (cfg_timeout < 64) ? 32'd0 : 32'($urandom_range(0, 10));
    endtask

    // One capture attempt from start to shutdown, answers mostly good
    task automatic gen_session();
        logic [15:0] img_size;
        logic [15:0] got;
        logic [15:0] len;
        logic [15:0] size;
        logic [7:0]  health;
        logic        ok;
        logic        advanced;
        int          tries;
        int          pkts;
        img_size = '0;
        gen_ms += 32'($urandom_range(0, 20));
        put_item(OP_START, gen_ms, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        for (int p = 0; p < 6; p++) begin
            if (p == 4) begin
                got  = '0;
                pkts = 0;
                while (img_size != 0 && got < img_size && pkts < 10) begin
                    issue_tick();
                    ok = ($urandom_range(0, 9) != 0);
                    case ($urandom_range(0, 9))
                        0:       len = 16'd0;
                        1, 2:    len = 16'($urandom);
                        default: len = 16'($urandom_range(1, img_size - got));
                    endcase
                    put_item(OP_RESP, gen_ms, ok, 8'($urandom), 16'($urandom), len);
                    if (ok && len != 0 && ({1'b0, got} + {1'b0, len}) <= {1'b0, cfg_capacity})
                        got += len;
                    pkts++;
                end
            end else begin
                advanced = 1'b0;
                tries    = 0;
                while (!advanced && tries < 4) begin
                    issue_tick();
                    ok     = ($urandom_range(0, 9) != 0);
                    health = (p == 1 && $urandom_range(0, 4) != 0) ? 8'd0 : 8'($urandom);
                    size   = 16'($urandom);
                    if (p == 3) begin
                        case ($urandom_range(0, 9))
                            0: size = 16'd0;
                            1: size = (cfg_capacity == 16'hFFFF) ? 16'($urandom) :
                                      16'($urandom_range(cfg_capacity + 1, 65535));
                            default: size = (cfg_capacity == 0) ? 16'($urandom) :
                                      16'($urandom_range(1, (cfg_capacity < 1500) ?
                                                            cfg_capacity : 1500));
                        endcase
                    end
                    put_item(OP_RESP, gen_ms, ok, health, size, 16'($urandom));
                    advanced = ok && (p != 1 || health == 0) &&
                               (p != 3 || (size != 0 && size <= cfg_capacity));
                    if (advanced && p == 3)
                        img_size = size;
                    tries++;
                end
            end
        end
    endtask

    task automatic fill_random(int target);
        phase_items = 0;
        while (phase_items < target)
            gen_session();
    endtask

    // Let everything drain, then let the one-deep output stage settle
    task automatic wait_quiet();
        while (capture_items.size() != 0 || in_valid || awaited_outputs.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Register writes only while idle; upper data bits of the 16-bit register
    // and the spare index carry junk that must be ignored.
    task automatic program_regs(logic [15:0] cap, logic [31:0] tmo, logic [31:0] retry);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BUFFER_CAPACITY;
        i_cfg_data <= {16'($urandom), cap};
        cfg_capacity = cap;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PHASE_TIMEOUT_MS;
        i_cfg_data <= tmo;
        cfg_timeout = tmo;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RETRY_INTERVAL_MS;
        i_cfg_data <= retry;
        cfg_retry = retry;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IDX_SPARE;
        i_cfg_data <= $urandom;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps. A new item is
    // loaded only once the current one was taken at the last rising edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (gap_left != 0 || capture_items.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end else begin
                in_valid   <= 1'b1;
                in_payload <= capture_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the ready pattern switches periodically between always
    // ready, sparse random stalls, coin flips, a periodic beat and long
    // stalls alternating with equally long ready stretches.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 4);
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= 1'($urandom_range(0, 1));
            3:       out_ready <= ((rx_cycle % 7) < 4);
            default: out_ready <= ((rx_cycle / 8) % 2 == 0);
        endcase
        rx_cycle++;
    end

    // ------------------------------------------------------------------
    // Monitor: result transfers are checked against the oldest prediction;
    // each input transfer is run through the model at the edge it happens.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && dut_in.ready;
            if (dut_out.valid && out_ready) begin
                if (awaited_outputs.size() == 0) begin
                    report("result transfer with nothing pending");
                end else begin
                    want = awaited_outputs.pop_front();
                    check_field("query_kind", 32'(dut_out.payload.query_kind),
                                32'(want.query_kind));
                    check_field("resend_request", 32'(dut_out.payload.resend_request),
                                32'(want.resend_request));
                    check_field("write_offset", 32'(dut_out.payload.write_offset),
                                32'(want.write_offset));
                    check_field("write_enable", 32'(dut_out.payload.write_enable),
                                32'(want.write_enable));
                    check_field("run_status", 32'(dut_out.payload.run_status),
                                32'(want.run_status));
                    check_field("bytes_total", 32'(dut_out.payload.bytes_total),
                                32'(want.bytes_total));
                end
            end
            if (in_valid && dut_in.ready)
                awaited_outputs.push_back(sequence_item(in_payload));
        end
    end

    // Watchdog: too long without any transfer on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && dut_in.ready) || (dut_out.valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("image_capture_query_sequencer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run on reset register values (cap 65535, timeout 30000, retry 100)
        put_item(OP_TICK, 32'd0, 1'b0, 8'd0, 16'd0, 16'd0);     // idle: nothing, reads done
        put_item(OP_RESP, 32'd1, 1'b1, 8'd0, 16'd0, 16'd0);     // answer while idle
        put_item(OP_IGNORED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
        put_item(OP_START, 32'd10, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_TICK, 32'd50, 1'b0, 8'd0, 16'd0, 16'd0);    // first try not yet due
        put_item(OP_RESP, 32'd60, 1'b1, 8'd0, 16'd0, 16'd0);    // nothing outstanding
        put_item(OP_TICK, 32'd100, 1'b0, 8'd0, 16'd0, 16'd0);   // handshake
        put_item(OP_TICK, 32'd150, 1'b0, 8'd0, 16'd0, 16'd0);   // spacing not reached
        put_item(OP_TICK, 32'd200, 1'b0, 8'd0, 16'd0, 16'd0);   // reissue while outstanding
        put_item(OP_RESP, 32'd210, 1'b0, 8'd0, 16'd0, 16'd0);   // failed, phase holds
        put_item(OP_TICK, 32'd300, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd305, 1'b1, 8'd0, 16'd0, 16'd0);   // on to health
        put_item(OP_TICK, 32'd400, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd405, 1'b1, 8'hFF, 16'd0, 16'd0);  // unhealthy, retry
        put_item(OP_TICK, 32'd500, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd505, 1'b1, 8'd0, 16'd0, 16'd0);   // params
        put_item(OP_TICK, 32'd600, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd605, 1'b1, 8'd0, 16'd0, 16'd0);   // size
        put_item(OP_TICK, 32'd700, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd705, 1'b1, 8'd0, 16'd0, 16'd0);   // zero size rejected
        put_item(OP_TICK, 32'd800, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd805, 1'b1, 8'd0, 16'hFFFF, 16'd0); // full buffer size
        put_item(OP_TICK, 32'd900, 1'b0, 8'd0, 16'd0, 16'd0);
        put_item(OP_RESP, 32'd905, 1'b1, 8'd0, 16'd0, 16'd0);   // empty packet
        put_item(OP_TICK, 32'd1000, 1'b0, 8'd0, 16'd0, 16'd0);  // resend requested
        put_item(OP_RESP, 32'd1005, 1'b1, 8'd0, 16'd0, 16'hFFFF); // whole image, shutdown
        put_item(OP_START, 32'd1100, 1'b0, 8'd0, 16'd0, 16'd0); // restart mid-run
        put_item(OP_TICK, 32'd31101, 1'b0, 8'd0, 16'd0, 16'd0); // past timeout: error
        put_item(OP_RESP, 32'd31102, 1'b1, 8'd0, 16'd0, 16'd0); // ignored in error

        gen_ms = $urandom;
        fill_random(80);
        wait_quiet();

        // Zero capacity, endless timeout, no retry spacing
        program_regs(16'd0, 32'hFFFF_FFFF, 32'd0);
        gen_ms = $urandom;
        fill_random(50);
        wait_quiet();

        // Small buffer, short timeout: oversize images and timeouts are common
        program_regs(16'd1000, 32'd400, 32'd50);
        gen_ms = $urandom;
        fill_random(80);
        wait_quiet();

        // Zero timeout, zero spacing: only same-millisecond ticks survive
        program_regs(16'hFFFF, 32'd0, 32'd0);
        gen_ms = $urandom;
        fill_random(60);
        wait_quiet();

        // One-byte buffer, maximal spacing; clock starts just below the wrap
        program_regs(16'd1, 32'd1000, 32'hFFFF_FFFF);
        gen_ms = 32'hFFFF_FFF0;
        fill_random(40);
        wait_quiet();

        program_regs(16'($urandom_range(200, 65535)), 32'($urandom_range(100, 5000)),
                     32'($urandom_range(0, 100)));
        gen_ms = $urandom;
        fill_random(90);
        wait_quiet();

        if (mismatches == 0)
            $display("image_capture_query_sequencer verification clean");
        else
            $display("image_capture_query_sequencer verification failed");
        $finish;
    end

endmodule
